### design/hfc_pkg.sv
// Types, constants and the CRC-16/X.25 byte update for the HDLC frame checker.
// No dependencies; imported by hfc_frame_core and hdlc_frame_checker.
package hfc_pkg;

   localparam int HEADER_BYTES = 11;

   localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
   localparam logic [9:0]  LEN_MASK   = 10'h3FF;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [9:0]  LEN_EMPTY  = 10'd10;
   localparam logic [9:0]  LEN_MIN    = 10'd12;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_OPEN  = 3'd1,
      ST_BAD_LEN   = 3'd2,
      ST_BAD_HCS   = 3'd3,
      ST_BAD_FCS   = 3'd4,
      ST_BAD_CLOSE = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
   } hfc_req_type;

   typedef struct packed {
      status_type  status;
      logic [9:0]  data_length;
      logic [10:0] frame_length;
   } hfc_rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### design/hfc_frame_core.sv
// Frame state and per-beat check logic: position, CRC, header and length fields.
// Depends on hfc_pkg; instantiated by hdlc_frame_checker.
module hfc_frame_core
   import hfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  hfc_req_type req,
   output logic        res_valid,
   output hfc_rsp_type res
);

   logic        active_ff,  active_in;
   logic [10:0] pos_ff,     pos_in;
   logic [15:0] crc_ff,     crc_in;
   logic [15:0] hcs_ff,     hcs_in;
   logic [15:0] fcs_ff,     fcs_in;
   logic [7:0]  fmt_hi_ff,  fmt_hi_in;
   logic [7:0]  low_ff,     low_in;
   logic [9:0]  dlen_ff,    dlen_in;
   logic [10:0] flen_ff,    flen_in;

   logic [15:0] crc_upd;
   logic [15:0] crc_after;
   logic [10:0] data_end;
   logic        in_crc;
   logic        has_data;
   logic [9:0]  len_field;
   logic [9:0]  len_data;
   logic [11:0] pos_plus;

   assign crc_upd   = crc_byte(crc_ff, req.data_byte);
   assign data_end  = 11'd10 + {1'b0, dlen_ff};
   assign in_crc    = (pos_ff <= data_end);
   assign crc_after = in_crc ? crc_upd : crc_ff;
   assign has_data  = (dlen_ff != 10'd0);
   assign len_field = {fmt_hi_ff[1:0], req.data_byte} & LEN_MASK;
   assign len_data  = len_field - LEN_MIN;
   assign pos_plus  = {1'b0, pos_ff} + 12'd1;

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      hcs_in    = hcs_ff;
      fcs_in    = fcs_ff;
      fmt_hi_in = fmt_hi_ff;
      low_in    = low_ff;
      dlen_in   = dlen_ff;
      flen_in   = flen_ff;
      res_valid = 1'b0;
      res.status       = ST_OK;
      res.data_length  = dlen_ff;
      res.frame_length = flen_ff;
      if (accept) begin
         if (req.first) begin
            active_in = 1'b1;
            pos_in    = 11'd1;
            crc_in    = CRC_INIT;
            hcs_in    = 16'h0000;
            fcs_in    = 16'h0000;
            fmt_hi_in = 8'h00;
            low_in    = 8'h00;
            dlen_in   = 10'd0;
            flen_in   = 11'd0;
            if (req.data_byte != FLAG_BYTE) begin
               res_valid        = 1'b1;
               res.status       = ST_BAD_OPEN;
               res.data_length  = 10'd0;
               res.frame_length = 11'd0;
            end
         end else if (active_ff) begin
            pos_in = pos_ff + 11'd1;
            crc_in = crc_after;
            if (pos_ff == 11'd1) begin
               fmt_hi_in = req.data_byte;
            end else if (pos_ff == 11'd2) begin
               if (len_field == LEN_EMPTY || len_field == LEN_MIN) begin
                  dlen_in = 10'd0;
                  flen_in = 11'(HEADER_BYTES + 1);
               end else if (len_field > LEN_MIN) begin
                  dlen_in = len_data;
                  flen_in = 11'(HEADER_BYTES + 3) + {1'b0, len_data};
               end else begin
                  res_valid        = 1'b1;
                  res.status       = ST_BAD_LEN;
                  res.data_length  = 10'd0;
                  res.frame_length = 11'd0;
               end
            end else begin
               if (pos_ff == 11'd8) begin
                  hcs_in = ~crc_after;
               end
               if (pos_ff == 11'd9) begin
                  low_in = req.data_byte;
               end else if (pos_ff == 11'd10 && {req.data_byte, low_ff} != hcs_ff) begin
                  res_valid  = 1'b1;
                  res.status = ST_BAD_HCS;
               end else if (has_data && pos_ff == data_end) begin
                  fcs_in = ~crc_after;
               end else if (has_data && pos_ff == data_end + 11'd1) begin
                  low_in = req.data_byte;
               end else if (has_data && pos_ff == data_end + 11'd2) begin
                  if ({req.data_byte, low_ff} != fcs_ff) begin
                     res_valid  = 1'b1;
                     res.status = ST_BAD_FCS;
                  end
               end else if (pos_plus == {1'b0, flen_ff}) begin
                  res_valid  = 1'b1;
                  res.status = (req.data_byte == FLAG_BYTE) ? ST_OK : ST_BAD_CLOSE;
               end
            end
         end
         if (res_valid) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= 11'd0;
         crc_ff    <= CRC_INIT;
         hcs_ff    <= 16'h0000;
         fcs_ff    <= 16'h0000;
         fmt_hi_ff <= 8'h00;
         low_ff    <= 8'h00;
         dlen_ff   <= 10'd0;
         flen_ff   <= 11'd0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         hcs_ff    <= hcs_in;
         fcs_ff    <= fcs_in;
         fmt_hi_ff <= fmt_hi_in;
         low_ff    <= low_in;
         dlen_ff   <= dlen_in;
         flen_ff   <= flen_in;
      end
   end

endmodule

### design/hdlc_frame_checker.sv
// HDLC frame checker with CRC-16/X.25 header and frame check sequences.
// Top level: hfc_frame_core plus the result register and skid beat; uses hfc_pkg.
// Takes one received byte per cycle while req_stall is low and checks it in one pass: the CRC
// byte update and the position compares sit between the frame state registers, so a new beat
// is taken every unstalled cycle; the status of a closing or failing byte is registered.
// req_stall rises only when a result is held in the skid stage behind a stalled output,
// and is driven from a register.
module hdlc_frame_checker
   import hfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hfc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hfc_rsp_type rsp_data
);

   logic        accept;
   logic        res_valid;
   hfc_rsp_type res;

   logic        out_valid_ff, out_valid_in;
   hfc_rsp_type out_ff,       out_in;
   logic        skid_valid_ff, skid_valid_in;
   hfc_rsp_type skid_ff,       skid_in;
   logic        out_free;

   assign accept = req_valid && !skid_valid_ff;

   hfc_frame_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .res_valid (res_valid),
      .res       (res)
   );

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
